FILE: hdl/tlls_pkg.sv
// Shared types, constants and codes of the terrain LOD index stitcher.
`timescale 1ns / 1ps
package tlls_pkg;

    localparam int MAX_TILE_SIZE = 128;
    localparam int MAX_LOD_GAP   = 5;

    localparam int COORD_W = 8;   // vertex coordinate 0..MAX_TILE_SIZE
    localparam int VIDX_W  = 15;  // vertex index
    localparam int TRI_W   = 6;   // triangle counter, up to 2^MAX_LOD_GAP + 1 triangles
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOD_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STITCH_MASK = 2'd2;

    localparam logic [7:0] TILE_SIZE_RST = 8'd64;

    // command codes
    localparam logic CMD_QUAD = 1'b0;
    localparam logic CMD_EDGE = 1'b1;

    // edge codes, also bit positions in stitch_mask
    localparam logic [1:0] EDGE_NORTH = 2'd0;
    localparam logic [1:0] EDGE_EAST  = 2'd1;
    localparam logic [1:0] EDGE_SOUTH = 2'd2;
    localparam logic [1:0] EDGE_WEST  = 2'd3;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [VIDX_W-1:0]  t_vidx;
    typedef logic [TRI_W-1:0]   t_tri;

    // Laid out as {tuser, tdata[24:0]}: cell_x in the lowest bits.
    typedef struct packed {
        logic       command;
        logic [5:0] segment_index;
        logic [2:0] neighbor_lod;
        logic [1:0] edge_req;
        logic [6:0] cell_z;
        logic [6:0] cell_x;
    } t_item;

    // Walk plan for one item, worked out once before the triangles start.
    typedef struct packed {
        logic   fault;
        logic   is_edge;
        logic   horiz;       // edge runs along x (north or south)
        logic   dir_neg;     // walk toward lower coordinates
        t_coord step;
        t_coord j;           // segment start along the edge
        t_coord js;          // segment end along the edge
        t_coord across;      // edge row
        t_coord across_row;  // inner row one step in
        t_tri   half;        // fan triangles on each side of the middle one
        t_tri   u_first;
        t_tri   u_last;
        t_coord p_start;     // inner-row position of the first triangle
    } t_plan;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FAULT,
        ST_C0,
        ST_C1,
        ST_C2,
        ST_PUSH
    } t_state;

endpackage

FILE: hdl/tlls_vidx_unit.sv
// Shared vertex index unit: registered z*(T+1)+x.
`timescale 1ns / 1ps
module tlls_vidx_unit (
    input  logic           i_clk,
    input  tlls_pkg::t_coord i_x,
    input  tlls_pkg::t_coord i_z,
    input  logic [7:0]     i_tile_size,
    output tlls_pkg::t_vidx  o_idx
);

    logic [8:0]  w_row_len;
    logic [16:0] w_prod;
    logic [17:0] w_sum;
    tlls_pkg::t_vidx r_idx;
    tlls_pkg::t_vidx n_idx;

    always_comb begin
        w_row_len = {1'b0, i_tile_size} + 9'd1;
        w_prod    = 17'(i_z) * 17'(w_row_len);
        w_sum     = {1'b0, w_prod} + 18'(i_x);
        n_idx     = w_sum[tlls_pkg::VIDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    assign o_idx = r_idx;

endmodule

FILE: hdl/tlls_check.sv
// Request check and walk planning for one item.
`timescale 1ns / 1ps
module tlls_check (
    input  tlls_pkg::t_item i_item,
    input  logic [7:0]      i_tile_size,
    input  logic [2:0]      i_lod_level,
    input  logic [3:0]      i_stitch_mask,
    output tlls_pkg::t_plan o_plan
);

    logic [7:0]  step;
    logic        tile_ok;
    logic [8:0]  x9, z9, w, e, s, n, t9;
    logic        quad_bad;
    logic [2:0]  gap;
    logic [7:0]  sup;
    logic [13:0] seg_off;
    logic        last_seg;
    logic        edge_bad;
    logic        is_north, is_east, is_south, is_west;
    logic        omit_first, omit_last;
    logic [7:0]  j;
    tlls_pkg::t_tri half;

    always_comb begin
        step    = 8'd1 << i_lod_level;
        tile_ok = (i_tile_size >= 8'd2) &&
                  (9'(i_tile_size) <= 9'(tlls_pkg::MAX_TILE_SIZE)) &&
                  ((i_tile_size & (i_tile_size - 8'd1)) == 8'd0) &&
                  (step <= i_tile_size);

        // interior quad
        x9 = 9'(i_item.cell_x);
        z9 = 9'(i_item.cell_z);
        t9 = 9'(i_tile_size);
        w  = i_stitch_mask[tlls_pkg::EDGE_WEST]  ? 9'(step) : 9'd0;
        e  = i_stitch_mask[tlls_pkg::EDGE_EAST]  ? 9'(step) : 9'd0;
        s  = i_stitch_mask[tlls_pkg::EDGE_SOUTH] ? 9'(step) : 9'd0;
        n  = i_stitch_mask[tlls_pkg::EDGE_NORTH] ? 9'(step) : 9'd0;
        quad_bad = ((i_item.cell_x & step[6:0] - 7'd1) != 7'd0) ||
                   ((i_item.cell_z & step[6:0] - 7'd1) != 7'd0) ||
                   (x9 < w) || (z9 < s) ||
                   (x9 + 9'(step) > t9 - e) || (z9 + 9'(step) > t9 - n);

        // edge segment
        is_north = (i_item.edge_req == tlls_pkg::EDGE_NORTH);
        is_east  = (i_item.edge_req == tlls_pkg::EDGE_EAST);
        is_south = (i_item.edge_req == tlls_pkg::EDGE_SOUTH);
        is_west  = (i_item.edge_req == tlls_pkg::EDGE_WEST);
        gap      = i_item.neighbor_lod - i_lod_level;
        sup      = 8'd1 << i_item.neighbor_lod;
        seg_off  = 14'(i_item.segment_index) << i_item.neighbor_lod;
        last_seg = (seg_off + 14'(sup)) == 14'(i_tile_size);
        edge_bad = !i_stitch_mask[i_item.edge_req] ||
                   (i_item.neighbor_lod <= i_lod_level) ||
                   (3'(gap) > 3'(tlls_pkg::MAX_LOD_GAP)) ||
                   (sup > i_tile_size) ||
                   (seg_off >= 14'(i_tile_size));
        half     = tlls_pkg::t_tri'(1) << (gap - 3'd1);

        case (i_item.edge_req)
            tlls_pkg::EDGE_NORTH: begin
                omit_first = i_stitch_mask[tlls_pkg::EDGE_EAST];
                omit_last  = i_stitch_mask[tlls_pkg::EDGE_WEST];
            end
            tlls_pkg::EDGE_EAST: begin
                omit_first = i_stitch_mask[tlls_pkg::EDGE_SOUTH];
                omit_last  = i_stitch_mask[tlls_pkg::EDGE_NORTH];
            end
            tlls_pkg::EDGE_SOUTH: begin
                omit_first = i_stitch_mask[tlls_pkg::EDGE_WEST];
                omit_last  = i_stitch_mask[tlls_pkg::EDGE_EAST];
            end
            default: begin
                omit_first = i_stitch_mask[tlls_pkg::EDGE_NORTH];
                omit_last  = i_stitch_mask[tlls_pkg::EDGE_SOUTH];
            end
        endcase

        j = (is_north || is_west) ? i_tile_size - seg_off[7:0] : seg_off[7:0];

        o_plan.is_edge    = (i_item.command == tlls_pkg::CMD_EDGE);
        o_plan.fault      = !tile_ok || (o_plan.is_edge ? edge_bad : quad_bad);
        o_plan.horiz      = is_north || is_south;
        o_plan.dir_neg    = is_north || is_west;
        o_plan.step       = step;
        o_plan.j          = j;
        o_plan.js         = o_plan.dir_neg ? j - sup : j + sup;
        o_plan.across     = (is_north || is_east) ? i_tile_size : 8'd0;
        o_plan.across_row = (is_north || is_east) ? i_tile_size - step : step;
        o_plan.half       = half;
        if (o_plan.is_edge) begin
            o_plan.u_first = tlls_pkg::t_tri'((i_item.segment_index == 6'd0) && omit_first);
            o_plan.u_last  = (half << 1) - tlls_pkg::t_tri'(last_seg && omit_last);
        end else begin
            o_plan.u_first = '0;
            o_plan.u_last  = tlls_pkg::t_tri'(1);
        end
        if (o_plan.u_first != '0) begin
            o_plan.p_start = o_plan.dir_neg ? j - step : j + step;
        end else begin
            o_plan.p_start = j;
        end
    end

endmodule

FILE: hdl/terrain_lod_list_index_stitcher_top.sv
// Top level of the terrain LOD index stitcher: config, sequencer and output register.
`timescale 1ns / 1ps
// Turns quad and edge-stitch commands for one terrain tile into triangle-list
// vertex indices, one output item per triangle, with tlast on the final
// triangle of each command and tuser set (all indices zero) on a faulting
// command. An accepted item is first checked in state CHECK; each triangle
// then passes through states C0, C1, C2 and PUSH, because every vertex index
// goes through the one shared multiply-add unit (z*(T+1)+x), one corner per
// cycle, and PUSH hands the triangle to the output register. A quad yields
// two triangles, an edge segment N triangles (N up to 33), a fault a single
// item; PUSH and FAULT wait while the output register holds an untaken item.
// The input is taken only while the sequencer is idle, but a finished
// triangle may still sit in the output register then. Configuration writes
// are always taken and must only be issued while no command is in flight.
module terrain_lod_list_index_stitcher_top (
    input  logic i_clk,
    input  logic i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tlls_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tlls_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // command stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [6:0] cell_x, [13:7] cell_z, [15:14] edge_req, [18:16] neighbor_lod,
    // [24:19] segment_index, [31:25] zero
    input  logic [tlls_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  logic                            s_axis_tuser,
    // triangle stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [14:0] vertex_a, [29:15] vertex_b, [44:30] vertex_c, [47:45] zero
    output logic [tlls_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [0] fault
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);

    // configuration registers
    logic [7:0] r_tile_size;
    logic [2:0] r_lod_level;
    logic [3:0] r_stitch_mask;

    tlls_pkg::t_state r_state, n_state;
    tlls_pkg::t_item  r_item;
    tlls_pkg::t_plan  r_plan, w_plan;
    tlls_pkg::t_tri   r_u;
    tlls_pkg::t_coord r_p;
    tlls_pkg::t_vidx  r_va, r_vb, w_idx;

    logic                            r_out_valid;
    logic [tlls_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                            r_out_fault;
    logic                            r_out_last;

    logic             w_out_free;
    logic             w_take;
    logic             w_last_tri;
    tlls_pkg::t_coord w_x, w_z;
    tlls_pkg::t_coord c0_al, c0_ac, c1_al, c1_ac, c2_al, c2_ac;
    tlls_pkg::t_coord sel_al, sel_ac, p_next;
    tlls_pkg::t_coord qx, qz, qxs, qzs;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == tlls_pkg::ST_IDLE);
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_last_tri    = (r_u == r_plan.u_last);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_fault;
    assign m_axis_tlast  = r_out_last;

    tlls_check u_check (
        .i_item        (r_item),
        .i_tile_size   (r_tile_size),
        .i_lod_level   (r_lod_level),
        .i_stitch_mask (r_stitch_mask),
        .o_plan        (w_plan)
    );

    tlls_vidx_unit u_vidx (
        .i_clk       (i_clk),
        .i_x         (w_x),
        .i_z         (w_z),
        .i_tile_size (r_tile_size),
        .o_idx       (w_idx)
    );

    // Corner coordinates of the current triangle. Edge corners are kept as
    // (along, across) and swapped into (x, z) for east and west edges.
    always_comb begin
        qx     = tlls_pkg::t_coord'(r_item.cell_x);
        qz     = tlls_pkg::t_coord'(r_item.cell_z);
        qxs    = qx + r_plan.step;
        qzs    = qz + r_plan.step;
        p_next = r_plan.dir_neg ? r_p - r_plan.step : r_p + r_plan.step;

        if (r_plan.is_edge) begin
            // lower fan hangs off the segment start, upper fan off its end
            c0_al = (r_u > r_plan.half) ? r_plan.js : r_plan.j;
            c0_ac = r_plan.across;
            c1_al = r_p;
            c1_ac = r_plan.across_row;
            if (r_u == r_plan.half) begin
                c2_al = r_plan.js;
                c2_ac = r_plan.across;
            end else begin
                c2_al = p_next;
                c2_ac = r_plan.across_row;
            end
        end else if (r_u == '0) begin
            c0_al = qx;  c0_ac = qz;
            c1_al = qx;  c1_ac = qzs;
            c2_al = qxs; c2_ac = qz;
        end else begin
            c0_al = qx;  c0_ac = qzs;
            c1_al = qxs; c1_ac = qzs;
            c2_al = qxs; c2_ac = qz;
        end

        case (r_state)
            tlls_pkg::ST_C0: begin
                sel_al = c0_al; sel_ac = c0_ac;
            end
            tlls_pkg::ST_C1: begin
                sel_al = c1_al; sel_ac = c1_ac;
            end
            default: begin
                sel_al = c2_al; sel_ac = c2_ac;
            end
        endcase

        if (r_plan.is_edge && !r_plan.horiz) begin
            w_x = sel_ac;
            w_z = sel_al;
        end else begin
            w_x = sel_al;
            w_z = sel_ac;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlls_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = tlls_pkg::ST_CHECK;
            end
            tlls_pkg::ST_CHECK: begin
                n_state = w_plan.fault ? tlls_pkg::ST_FAULT : tlls_pkg::ST_C0;
            end
            tlls_pkg::ST_FAULT: begin
                if (w_out_free) n_state = tlls_pkg::ST_IDLE;
            end
            tlls_pkg::ST_C0: n_state = tlls_pkg::ST_C1;
            tlls_pkg::ST_C1: n_state = tlls_pkg::ST_C2;
            tlls_pkg::ST_C2: n_state = tlls_pkg::ST_PUSH;
            tlls_pkg::ST_PUSH: begin
                if (w_out_free) begin
                    n_state = w_last_tri ? tlls_pkg::ST_IDLE : tlls_pkg::ST_C0;
                end
            end
            default: n_state = tlls_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tlls_pkg::ST_IDLE;
            r_tile_size   <= tlls_pkg::TILE_SIZE_RST;
            r_lod_level   <= 3'd0;
            r_stitch_mask <= 4'd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tlls_pkg::CFG_TILE_SIZE:   r_tile_size   <= i_cfg_data;
                    tlls_pkg::CFG_LOD_LEVEL:   r_lod_level   <= i_cfg_data[2:0];
                    tlls_pkg::CFG_STITCH_MASK: r_stitch_mask <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // load a new triangle, else drop the one taken downstream
            if (((r_state == tlls_pkg::ST_FAULT) || (r_state == tlls_pkg::ST_PUSH)) &&
                w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= tlls_pkg::t_item'({s_axis_tuser, s_axis_tdata[24:0]});
        end
        case (r_state)
            tlls_pkg::ST_CHECK: begin
                r_plan <= w_plan;
                r_u    <= w_plan.u_first;
                r_p    <= w_plan.p_start;
            end
            tlls_pkg::ST_C1: r_va <= w_idx;
            tlls_pkg::ST_C2: r_vb <= w_idx;
            tlls_pkg::ST_FAULT: begin
                if (w_out_free) begin
                    r_out_data  <= '0;
                    r_out_fault <= 1'b1;
                    r_out_last  <= 1'b1;
                end
            end
            tlls_pkg::ST_PUSH: begin
                if (w_out_free) begin
                    r_out_data  <= {3'b000, w_idx, r_vb, r_va};
                    r_out_fault <= 1'b0;
                    r_out_last  <= w_last_tri;
                    r_u         <= r_u + tlls_pkg::t_tri'(1);
                    // the middle triangle shares its inner vertex with the next one
                    if (r_u != r_plan.half) r_p <= p_next;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: dv/triangle_index_checker.sv
// Checker for the terrain LOD index stitcher: predicts triangle indices and compares them.
`timescale 1ns / 1ps
module triangle_index_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [tlls_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tlls_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    input  logic                                i_cmd_valid,
    input  logic                                i_cmd_ready,
    input  logic [tlls_pkg::IN_DATA_W-1:0]      i_cmd_data,
    input  logic                                i_cmd_user,
    input  logic                                i_tri_valid,
    input  logic                                i_tri_ready,
    input  logic [tlls_pkg::OUT_DATA_W-1:0]     i_tri_data,
    input  logic                                i_tri_user,
    input  logic                                i_tri_last,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);

    typedef struct packed {
        logic [14:0] vertex_a;
        logic [14:0] vertex_b;
        logic [14:0] vertex_c;
        logic        fault;
        logic        last;
    } triangle_t;

    triangle_t   pending_triangles[$];
    logic [7:0]  tile_size;
    logic [2:0]  lod_level;
    logic [3:0]  stitch_mask;
    int          fail_count;

    function automatic logic [14:0] vertex_index(int tile, int x, int z);
        return 15'(z * (tile + 1) + x);
    endfunction

    // Map a position along an edge and across it onto the grid.
    function automatic logic [14:0] edge_point(int tile, bit horiz, int along, int across);
        return horiz ? vertex_index(tile, along, across) : vertex_index(tile, across, along);
    endfunction

    function automatic void push_fault();
        pending_triangles.push_back('{15'd0, 15'd0, 15'd0, 1'b1, 1'b1});
    endfunction

    // Work out every triangle one command yields and queue them in order.
    function automatic void predict_triangles(logic cmd, logic [tlls_pkg::IN_DATA_W-1:0] data);
        triangle_t   fan[$];
        logic [1:0]  side;
        int          tile, step, x, z, lo_x, hi_x, lo_z, hi_z;
        int          nlod, seg, gap, seg_len, nseg, half;
        int          start, across, row, fine, coarse, mid, base, k;
        bit          horiz, omit_first, omit_last;

        tile = int'(tile_size);
        step = 1 << lod_level;
        if (tile < 2 || tile > tlls_pkg::MAX_TILE_SIZE || (tile & (tile - 1)) != 0 ||
            step > tile) begin
            push_fault();
            return;
        end

        if (cmd == tlls_pkg::CMD_QUAD) begin
            x    = int'(data[6:0]);
            z    = int'(data[13:7]);
            lo_x = stitch_mask[tlls_pkg::EDGE_WEST]  ? step : 0;
            lo_z = stitch_mask[tlls_pkg::EDGE_SOUTH] ? step : 0;
            hi_x = tile - (stitch_mask[tlls_pkg::EDGE_EAST]  ? step : 0);
            hi_z = tile - (stitch_mask[tlls_pkg::EDGE_NORTH] ? step : 0);
            if (x % step != 0 || z % step != 0 || x < lo_x || z < lo_z ||
                x + step > hi_x || z + step > hi_z) begin
                push_fault();
                return;
            end
            fan.push_back('{vertex_index(tile, x, z), vertex_index(tile, x, z + step),
                            vertex_index(tile, x + step, z), 1'b0, 1'b0});
            fan.push_back('{vertex_index(tile, x, z + step),
                            vertex_index(tile, x + step, z + step),
                            vertex_index(tile, x + step, z), 1'b0, 1'b0});
        end else begin
            side = data[15:14];
            nlod = int'(data[18:16]);
            seg  = int'(data[24:19]);
            gap  = nlod - int'(lod_level);
            if (!stitch_mask[side] || gap < 1 || gap > tlls_pkg::MAX_LOD_GAP) begin
                push_fault();
                return;
            end
            seg_len = 1 << nlod;
            if (seg_len > tile) begin
                push_fault();
                return;
            end
            nseg = tile / seg_len;
            if (seg >= nseg) begin
                push_fault();
                return;
            end
            half = 1 << (gap - 1);

            // Each edge is walked counterclockwise; row points one step into the tile.
            case (side)
                tlls_pkg::EDGE_NORTH: begin
                    start = tile; across = tile; row = -step; fine = -step; coarse = -seg_len;
                    horiz = 1'b1;
                    omit_first = stitch_mask[tlls_pkg::EDGE_EAST];
                    omit_last  = stitch_mask[tlls_pkg::EDGE_WEST];
                end
                tlls_pkg::EDGE_EAST: begin
                    start = 0; across = tile; row = -step; fine = step; coarse = seg_len;
                    horiz = 1'b0;
                    omit_first = stitch_mask[tlls_pkg::EDGE_SOUTH];
                    omit_last  = stitch_mask[tlls_pkg::EDGE_NORTH];
                end
                tlls_pkg::EDGE_SOUTH: begin
                    start = 0; across = 0; row = step; fine = step; coarse = seg_len;
                    horiz = 1'b1;
                    omit_first = stitch_mask[tlls_pkg::EDGE_WEST];
                    omit_last  = stitch_mask[tlls_pkg::EDGE_EAST];
                end
                default: begin
                    start = tile; across = 0; row = step; fine = -step; coarse = -seg_len;
                    horiz = 1'b0;
                    omit_first = stitch_mask[tlls_pkg::EDGE_NORTH];
                    omit_last  = stitch_mask[tlls_pkg::EDGE_SOUTH];
                end
            endcase
            mid  = coarse / 2;
            base = start + seg * coarse;

            for (int t = 0; t < half; t++) begin
                k = t * fine;
                if (seg == 0 && t == 0 && omit_first)
                    continue;
                fan.push_back('{edge_point(tile, horiz, base, across),
                                edge_point(tile, horiz, base + k, across + row),
                                edge_point(tile, horiz, base + k + fine, across + row),
                                1'b0, 1'b0});
            end
            fan.push_back('{edge_point(tile, horiz, base, across),
                            edge_point(tile, horiz, base + mid, across + row),
                            edge_point(tile, horiz, base + coarse, across), 1'b0, 1'b0});
            for (int t = 0; t < half; t++) begin
                k = mid + t * fine;
                if (seg == nseg - 1 && t == half - 1 && omit_last)
                    continue;
                fan.push_back('{edge_point(tile, horiz, base + coarse, across),
                                edge_point(tile, horiz, base + k, across + row),
                                edge_point(tile, horiz, base + k + fine, across + row),
                                1'b0, 1'b0});
            end
        end

        fan[fan.size() - 1].last = 1'b1;
        foreach (fan[i])
            pending_triangles.push_back(fan[i]);
    endfunction

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        triangle_t want;

        if (!i_rst_n) begin
            tile_size   = tlls_pkg::TILE_SIZE_RST;
            lod_level   = 3'd0;
            stitch_mask = 4'd0;
            pending_triangles.delete();
            fail_count  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tlls_pkg::CFG_TILE_SIZE:   tile_size   = i_cfg_data[7:0];
                    tlls_pkg::CFG_LOD_LEVEL:   lod_level   = i_cfg_data[2:0];
                    tlls_pkg::CFG_STITCH_MASK: stitch_mask = i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (i_tri_valid && i_tri_ready) begin
                if (pending_triangles.size() == 0) begin
                    $error("unexpected triangle %h fault %b last %b",
                           i_tri_data, i_tri_user, i_tri_last);
                    fail_count++;
                end else begin
                    want = pending_triangles.pop_front();
                    check_field("vertex_a", want.vertex_a, i_tri_data[14:0]);
                    check_field("vertex_b", want.vertex_b, i_tri_data[29:15]);
                    check_field("vertex_c", want.vertex_c, i_tri_data[44:30]);
                    check_field("fault", want.fault, i_tri_user);
                    check_field("last", want.last, i_tri_last);
                end
            end

            if (i_cmd_valid && i_cmd_ready)
                predict_triangles(i_cmd_user, i_cmd_data);
        end

        o_outstanding <= pending_triangles.size();
        o_fail_count  <= fail_count;
    end

endmodule

FILE: dv/terrain_lod_list_index_stitcher_top_test.sv
// Testbench top for the terrain LOD index stitcher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module terrain_lod_list_index_stitcher_top_test;

    localparam int HOLD_CYCLES    = 400;   // long downstream hold-off, fills the block
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no item moving on any channel
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 39;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [tlls_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [tlls_pkg::CFG_DAT_W-1:0]   i_cfg_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [tlls_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [tlls_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             m_axis_tlast;

    int   fail_count;
    int   outstanding;
    int   idle_cycles;
    int   burst_left;
    logic hold_req = 1'b0;

    // Configuration as the stimulus side sees it, used to shape legal commands.
    int   tile_cfg;
    int   lod_cfg;
    int   mask_cfg;

    terrain_lod_list_index_stitcher_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The checker watches all three channels beside the block and keeps the score.
    triangle_index_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_valid   (s_axis_tvalid),
        .i_cmd_ready   (s_axis_tready),
        .i_cmd_data    (s_axis_tdata),
        .i_cmd_user    (s_axis_tuser),
        .i_tri_valid   (m_axis_tvalid),
        .i_tri_ready   (m_axis_tready),
        .i_tri_data    (m_axis_tdata),
        .i_tri_user    (m_axis_tuser),
        .i_tri_last    (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // 12 ns clock period.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: end the run if no item moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                     (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: stall on a pattern whose mode is redrawn when mode_left runs out,
    // from never stalling to stalling most of the time. Once asked, hold off for a
    // long stretch so the block backs up into its command input.
    initial begin
        int stall_pct;
        int mode_left;
        bit hold_taken;

        stall_pct  = 0;
        mode_left  = 0;
        hold_taken = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(16, 96);
                    case ($urandom_range(2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 30;
                        default: stall_pct = 75;
                    endcase
                end
                mode_left--;
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one command and hold it until taken, then pace the sender: bursts
    // of random length with random gaps, some gaps zero so bursts run together.
    task automatic send_item(logic cmd, logic [6:0] cx, logic [6:0] cz, logic [1:0] side,
                             logic [2:0] nlod, logic [5:0] seg);
        int gap;

        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, seg, nlod, side, cz, cx};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);

        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Quads carry random junk in the edge fields, edge commands in the cell fields.
    task automatic send_quad(int x, int z);
        send_item(tlls_pkg::CMD_QUAD, 7'(x), 7'(z), 2'($urandom_range(3)),
                  3'($urandom_range(7)), 6'($urandom_range(63)));
    endtask

    task automatic send_edge(logic [1:0] side, int nlod, int seg);
        send_item(tlls_pkg::CMD_EDGE, 7'($urandom_range(127)), 7'($urandom_range(127)),
                  side, 3'(nlod), 6'(seg));
    endtask

    task automatic write_reg(logic [tlls_pkg::CFG_IDX_W-1:0] index, int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= tlls_pkg::CFG_DAT_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Write all three registers back to back; only call while the block is idle.
    task automatic set_config(int tile, int lod, int mask);
        tile_cfg = tile;
        lod_cfg  = lod;
        mask_cfg = mask;
        write_reg(tlls_pkg::CFG_TILE_SIZE, tile);
        write_reg(tlls_pkg::CFG_LOD_LEVEL, lod);
        write_reg(tlls_pkg::CFG_STITCH_MASK, mask);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait until every predicted triangle has come out.
    // The first edge lets the checker's count catch up with the last command.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One random configuration and a run of commands: mostly legal quads and
    // legal stitch segments, the rest raw commands that mostly fault.
    task automatic random_phase(int n_items, bit pressure);
        int log_tile, step, lo_x, hi_x, lo_z, hi_z, nlod_hi, nlod, nseg, seg, roll;
        int sides[$];
        bit tile_good;

        log_tile = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 7);
        tile_cfg = 1 << log_tile;
        if ($urandom_range(9) == 0)
            tile_cfg = $urandom_range(2, 128);
        if ($urandom_range(9) == 0)
            lod_cfg = $urandom_range(0, 6);
        else
            lod_cfg = $urandom_range(0, (log_tile > 6) ? 6 : log_tile);
        mask_cfg = $urandom_range(15);
        set_config(tile_cfg, lod_cfg, mask_cfg);
        if (pressure)
            hold_req <= 1'b1;

        step      = 1 << lod_cfg;
        tile_good = (tile_cfg == (1 << log_tile)) && (step <= tile_cfg);
        lo_x      = mask_cfg[3] ? step : 0;
        lo_z      = mask_cfg[2] ? step : 0;
        hi_x      = tile_cfg - (mask_cfg[1] ? step : 0) - step;
        hi_z      = tile_cfg - (mask_cfg[0] ? step : 0) - step;
        for (int s = 0; s < 4; s++)
            if (mask_cfg[s])
                sides.push_back(s);
        nlod_hi = lod_cfg + tlls_pkg::MAX_LOD_GAP;
        if (nlod_hi > 7)
            nlod_hi = 7;
        if (nlod_hi > log_tile)
            nlod_hi = log_tile;

        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < 45 && tile_good && hi_x >= lo_x && hi_z >= lo_z) begin
                send_quad(lo_x + step * $urandom_range(0, (hi_x - lo_x) / step),
                          lo_z + step * $urandom_range(0, (hi_z - lo_z) / step));
            end else if (roll < 85 && tile_good && sides.size() != 0 && nlod_hi > lod_cfg) begin
                // Favor the smallest gap; larger gaps give long fans.
                nlod = ($urandom_range(1) == 0) ? lod_cfg + 1 :
                       $urandom_range(lod_cfg + 1, nlod_hi);
                nseg = tile_cfg >> nlod;
                case ($urandom_range(3))
                    0:       seg = 0;
                    1:       seg = nseg - 1;
                    default: seg = $urandom_range(0, nseg - 1);
                endcase
                send_edge(2'(sides[$urandom_range(0, sides.size() - 1)]), nlod, seg);
            end else begin
                send_item(1'($urandom_range(1)), 7'($urandom_range(127)),
                          7'($urandom_range(127)), 2'($urandom_range(3)),
                          3'($urandom_range(7)), 6'($urandom_range(63)));
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= tlls_pkg::CFG_TILE_SIZE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= tlls_pkg::CMD_QUAD;
        burst_left    = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Largest tile, no stitching: corner quads and a stitch on an unstitched edge.
        set_config(128, 0, 0);
        send_quad(0, 0);
        send_quad(127, 127);
        send_quad(127, 0);
        send_edge(tlls_pkg::EDGE_NORTH, 1, 0);
        drain();

        // All edges stitched: border strip quads fault, corner fan triangles drop, widest fan,
        // and stitch requests refused for a gap too large, for no gap and for a segment past the tile.
        set_config(128, 0, 15);
        send_quad(0, 0);
        send_quad(1, 1);
        send_quad(126, 126);
        send_edge(tlls_pkg::EDGE_NORTH, 1, 0);
        send_edge(tlls_pkg::EDGE_EAST, 1, 63);
        send_edge(tlls_pkg::EDGE_SOUTH, 5, 0);
        send_edge(tlls_pkg::EDGE_WEST, 5, 3);
        send_edge(tlls_pkg::EDGE_NORTH, 6, 0);
        send_edge(tlls_pkg::EDGE_EAST, 0, 0);
        send_edge(tlls_pkg::EDGE_SOUTH, 5, 4);
        drain();

        // Smallest tile: one quad fills it; a segment longer than the tile faults.
        set_config(2, 1, 0);
        send_quad(0, 0);
        drain();
        set_config(2, 1, 15);
        send_edge(tlls_pkg::EDGE_SOUTH, 2, 0);
        drain();

        // Step larger than the tile, and a tile size that is not a power of two.
        set_config(2, 2, 0);
        send_quad(0, 0);
        drain();
        set_config(48, 0, 0);
        send_quad(0, 0);
        drain();

        // Coarsest stitchable level: aligned and misaligned quads, then a one-segment edge
        // whose first and last fan triangles both drop.
        set_config(128, 6, 0);
        send_quad(64, 64);
        send_quad(32, 0);
        drain();
        set_config(128, 6, 15);
        send_edge(tlls_pkg::EDGE_EAST, 7, 0);
        drain();

        // Random part; one phase runs against the long downstream hold-off.
        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(PHASE_ITEMS, p == 2);

        // Give stray triangles time to show up before the verdict.
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: terrain_lod_list_index_stitcher_top.f
hdl/tlls_pkg.sv
hdl/tlls_vidx_unit.sv
hdl/tlls_check.sv
hdl/terrain_lod_list_index_stitcher_top.sv
dv/triangle_index_checker.sv
dv/terrain_lod_list_index_stitcher_top_test.sv
